/* rtl/esa_pkg.sv */
// ----------------------------------------------------------------------------
// esa_pkg: shared types and constants for the expiring slot allocator
// command codes, status codes, the broadcast command and the sweep token
// ----------------------------------------------------------------------------
`default_nettype none

package esa_pkg;

	localparam int NUM_SLOTS_DEF = 128;

	localparam int IDX_W  = 7;
	localparam int LIFE_W = 16;
	localparam int CNT_W  = 8;
	localparam int STAT_W = 2;

	typedef enum logic [1:0] {
		OP_ALLOC    = 2'd0,
		OP_FREE     = 2'd1,
		OP_FREE_ALL = 2'd2,
		OP_TICK     = 2'd3
	} op_t;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_USED = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_HOLD
	} state_t;

	// command held steady for the whole sweep
	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  idx;
		logic [LIFE_W-1:0] life;
	} cmd_t;

	// token passed from cell to cell
	typedef struct packed {
		logic             valid;
		logic             found;
		logic [IDX_W-1:0] grant;
		logic [CNT_W-1:0] count;
	} tok_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] r;
		r = (n == {CNT_W{1'b1}}) ? n : n + CNT_W'(1);
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/esa_cell.sv */
// ----------------------------------------------------------------------------
// esa_cell: one slot of the pool
// holds the used flag and countdown, acts on the command when the token passes
// ----------------------------------------------------------------------------
`default_nettype none

module esa_cell #(
	parameter int CELL_ID = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  esa_pkg::cmd_t      bcast,
	input  esa_pkg::tok_t      tok_in,
	output esa_pkg::tok_t      tok_out
);
	import esa_pkg::*;

	// slots beyond the index range can never be named by a free
	localparam bit               IDX_REACH = (CELL_ID < (1 << IDX_W));
	localparam logic [IDX_W-1:0] MY_IDX    = IDX_W'(CELL_ID);

	logic              used_q, used_d;
	logic [LIFE_W-1:0] cnt_q, cnt_d;
	tok_t              tok_q, tok_d;

	always_comb begin
		used_d = used_q;
		cnt_d  = cnt_q;
		tok_d  = tok_in;
		if (tok_in.valid) begin
			case (bcast.op)
				OP_ALLOC: begin
					if (!tok_in.found && !used_q) begin
						used_d      = 1'b1;
						cnt_d       = bcast.life;
						tok_d.found = 1'b1;
						tok_d.grant = MY_IDX;
					end
				end
				OP_FREE: begin
					if (IDX_REACH && (bcast.idx == MY_IDX) && used_q) begin
						used_d      = 1'b0;
						cnt_d       = '0;
						tok_d.found = 1'b1;
					end
				end
				OP_FREE_ALL: begin
					if (used_q)
						tok_d.count = sat_inc(tok_in.count);
					used_d = 1'b0;
					cnt_d  = '0;
				end
				OP_TICK: begin
					if (used_q && (cnt_q != '0)) begin
						cnt_d = cnt_q - LIFE_W'(1);
						if (cnt_q == LIFE_W'(1)) begin
							used_d      = 1'b0;
							tok_d.count = sat_inc(tok_in.count);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			cnt_q  <= '0;
			tok_q  <= '0;
		end else begin
			used_q <= used_d;
			cnt_q  <= cnt_d;
			tok_q  <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

/* rtl/esa_ctrl.sv */
// ----------------------------------------------------------------------------
// esa_ctrl: command intake, sweep launch and result register
// takes one item, launches the token, builds the result from the last cell
// ----------------------------------------------------------------------------
`default_nettype none

module esa_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   cmd,
	input  wire logic [esa_pkg::IDX_W-1:0]    slot_index,
	input  wire logic [esa_pkg::LIFE_W-1:0]   lifetime,
	output esa_pkg::cmd_t                     bcast,
	output esa_pkg::tok_t                     tok_start,
	input  esa_pkg::tok_t                     tok_done,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [esa_pkg::STAT_W-1:0]        status,
	output logic [esa_pkg::IDX_W-1:0]         granted_slot,
	output logic [esa_pkg::CNT_W-1:0]         freed_count
);
	import esa_pkg::*;

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic   start_q;
	logic   accept;
	logic   load_out;

	logic [STAT_W-1:0] res_stat_q, res_stat_d;
	logic [IDX_W-1:0]  res_grant_q;
	logic [CNT_W-1:0]  res_cnt_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_stat_q;
	logic [IDX_W-1:0]  out_grant_q;
	logic [CNT_W-1:0]  out_cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SWEEP;
			ST_SWEEP: if (tok_done.valid) state_d = ST_HOLD;
			ST_HOLD:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		in_ready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_SWEEP: begin
			end
			ST_HOLD:  load_out = !out_valid_q || out_ready;
			default: begin
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_comb begin
		case (cmd_q.op)
			OP_ALLOC: res_stat_d = tok_done.found ? STAT_OK : STAT_FULL;
			OP_FREE:  res_stat_d = tok_done.found ? STAT_OK : STAT_NOT_USED;
			default:  res_stat_d = STAT_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= accept;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.op   <= op_t'(cmd);
			cmd_q.idx  <= slot_index;
			cmd_q.life <= lifetime;
		end
		if (tok_done.valid) begin
			res_stat_q  <= res_stat_d;
			res_grant_q <= tok_done.grant;
			res_cnt_q   <= tok_done.count;
		end
		if (load_out) begin
			out_stat_q  <= res_stat_q;
			out_grant_q <= res_grant_q;
			out_cnt_q   <= res_cnt_q;
		end
	end

	assign bcast           = cmd_q;
	assign tok_start.valid = start_q;
	assign tok_start.found = 1'b0;
	assign tok_start.grant = '0;
	assign tok_start.count = '0;

	assign out_valid    = out_valid_q;
	assign status       = out_stat_q;
	assign granted_slot = out_grant_q;
	assign freed_count  = out_cnt_q;

	// the token only comes back while a sweep is running
	a_done_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		tok_done.valid |-> state_q == ST_SWEEP)
		else $error("token returned outside a sweep");

	// every launched token belongs to an item just taken
	a_start_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> $past(accept) && state_q == ST_SWEEP)
		else $error("sweep launched without an accepted item");

	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !out_valid_q || out_ready)
		else $error("result register overwritten");

	// an allocate that finds no free slot answers pool-full
	a_full_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		tok_done.valid && !tok_done.found && cmd_q.op == OP_ALLOC
		|=> res_stat_q == STAT_FULL)
		else $error("missing full status");

endmodule

`default_nettype wire

/* rtl/expiring_slot_allocator.sv */
// ----------------------------------------------------------------------------
// expiring_slot_allocator: slot pool with per-slot lease countdowns
// a row of slot cells swept by a token, one cell per clock
// ----------------------------------------------------------------------------
// One item is handled at a time: a token walks the row of slot cells, one cell
// per clock, then the result passes a result register and the output register.
// The next item is taken once that result has moved into the output register,
// even while it still waits there; a result left waiting on the output holds
// the next one back until it is taken. Allocate grants the lowest free slot,
// free releases one slot, free-all clears the pool and tick counts every live
// lease down by one; a lifetime of zero never expires. freed_count saturates
// at 255 and granted_slot carries the low seven bits of the slot number.
`default_nettype none

module expiring_slot_allocator #(
	parameter int NUM_SLOTS = esa_pkg::NUM_SLOTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   cmd,
	input  wire logic [esa_pkg::IDX_W-1:0]    slot_index,
	input  wire logic [esa_pkg::LIFE_W-1:0]   lifetime,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [esa_pkg::STAT_W-1:0]        status,
	output logic [esa_pkg::IDX_W-1:0]         granted_slot,
	output logic [esa_pkg::CNT_W-1:0]         freed_count
);
	import esa_pkg::*;

	// command stays put for the whole sweep, so every cell sees it directly
	cmd_t bcast;

	// token chain: entry 0 is the launch, entry NUM_SLOTS returns to control
	tok_t tok [NUM_SLOTS+1];

	esa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.slot_index   (slot_index),
		.lifetime     (lifetime),
		.bcast        (bcast),
		.tok_start    (tok[0]),
		.tok_done     (tok[NUM_SLOTS]),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.granted_slot (granted_slot),
		.freed_count  (freed_count)
	);

	// slot cells, lowest index first so the first free slot wins an allocate
	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
		esa_cell #(
			.CELL_ID (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.bcast   (bcast),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1])
		);
	end

endmodule

`default_nettype wire
